// File: hw/rtl/qr_module_scale_and_pack_core_macros.svh
// assertion helpers shared by the rtl
// each expects clk and rst_n in the scope where it is used
`ifndef QR_MODULE_SCALE_AND_PACK_CORE_MACROS_SVH
`define QR_MODULE_SCALE_AND_PACK_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define QRSP_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define QRSP_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define QRSP_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/qrsp_pkg.sv
`timescale 1ns / 1ps

package qrsp_pkg;

  localparam int DEF_MAX_WIDTH = 177;
  localparam int DEF_MAX_SCALE = 5;
  localparam int MIN_WIDTH     = 21;
  localparam int WORD_BITS     = 64;
  localparam int BYTE_BITS     = 8;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd1;

  localparam logic [7:0] RST_SYMBOL_WIDTH = 8'd21;
  localparam logic [2:0] RST_SCALE        = 3'd5;

  typedef struct packed {
    logic [7:0] symbol_width;
    logic [2:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic [3:0]           byte_count;
    logic                 row_end;
    logic                 symbol_end;
    logic                 run_last;
  } beat_t;

endpackage

// File: hw/rtl/qrsp_line_mem.sv
`timescale 1ns / 1ps

module qrsp_line_mem #(
  parameter int DEPTH = 177,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem [DEPTH];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

// File: hw/rtl/qrsp_engine.sv
`timescale 1ns / 1ps

module qrsp_engine #(
  parameter int MAX_WIDTH = 177,
  parameter int MAX_SCALE = 5,
  parameter int AW_A      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qrsp_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_bit,
  output logic              out_valid,
  input  logic              out_ready,
  output qrsp_pkg::beat_t   out_beat,
  output logic              mem_wr_en,
  output logic [AW_A-1:0]   mem_wr_addr,
  output logic              mem_wr_bit,
  output logic              mem_rd_en,
  output logic [AW_A-1:0]   mem_rd_addr,
  input  logic              mem_rd_bit
);
  import qrsp_pkg::*;

  localparam int SCW  = $clog2(MAX_SCALE + 1);
  localparam int ACCW = WORD_BITS + MAX_SCALE - 1;
  localparam int FW   = $clog2(ACCW + 1);
  localparam int FW1  = FW + 1;

  localparam logic [1:0] ST_IN    = 2'd0;
  localparam logic [1:0] ST_RPL   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [7:0]     MAXW8  = 8'(MAX_WIDTH);
  localparam logic [7:0]     MINW8  = 8'(MIN_WIDTH);
  localparam logic [3:0]     MAXS4  = 4'(MAX_SCALE);
  localparam logic [SCW-1:0] ONE_S  = SCW'(1);
  localparam logic [FW1-1:0] WORD_F = FW1'(WORD_BITS);
  localparam logic [FW1-1:0] SEVEN  = FW1'(7);

  logic [1:0]      state_r, state_nxt;
  logic [7:0]      col_r, col_nxt;
  logic [7:0]      row_r, row_nxt;
  logic [7:0]      row_w_r, row_w_nxt;
  logic [SCW-1:0]  row_s_r, row_s_nxt;
  logic [ACCW-1:0] acc_r, acc_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [7:0]      iss_r, iss_nxt;
  logic [7:0]      pk_col_r, pk_col_nxt;
  logic            pk_v_r, pk_v_nxt;
  logic [SCW-1:0]  rep_r, rep_nxt;
  logic            sym_row_r, sym_row_nxt;

  logic            out_valid_r;
  beat_t           out_beat_r;

  logic            em_v;
  beat_t           em_beat;
  beat_t           em_out;
  logic [WORD_BITS-1:0] em_mask;

  logic [7:0]      cw_clamp;
  logic [SCW-1:0]  cs_clamp;
  logic [7:0]      eff_w;
  logic [SCW-1:0]  eff_s;
  logic [FW1-1:0]  newf_in;
  logic            row_last_in;
  logic            last_row_in;
  logic            emit_mid;
  logic [3:0]      mid_cnt;
  logic [ACCW-1:0] acc_in;
  logic            in_acc;

  logic [FW1-1:0]  newf_rp;
  logic            full_rp;
  logic            exact64;
  logic            pk_last;
  logic            final_pass;
  logic [ACCW-1:0] acc_rp;
  logic            slot_ok;
  logic            can_issue;
  logic            need_out;
  logic            pk_go;
  logic            advance;
  logic            rd_en;
  logic            pass_done;
  logic [FW1-1:0]  chk_fill;

  // register values are saturated into the supported range
  always_comb begin
    if (cfg.symbol_width < MINW8) begin
      cw_clamp = MINW8;
    end else if (cfg.symbol_width > MAXW8) begin
      cw_clamp = MAXW8;
    end else begin
      cw_clamp = cfg.symbol_width;
    end
    if (cfg.scale == 3'd0) begin
      cs_clamp = ONE_S;
    end else if ({1'b0, cfg.scale} > MAXS4) begin
      cs_clamp = SCW'(MAX_SCALE);
    end else begin
      cs_clamp = SCW'(cfg.scale);
    end
  end

  // width and scale are taken at the first module of a row
  assign eff_w = (col_r == 8'd0) ? cw_clamp : row_w_r;
  assign eff_s = (col_r == 8'd0) ? cs_clamp : row_s_r;

  assign newf_in     = FW1'(fill_r) + FW1'(eff_s);
  assign row_last_in = ({1'b0, col_r} + 9'd1) >= {1'b0, eff_w};
  assign last_row_in = ({1'b0, row_r} + 9'd1) >= {1'b0, eff_w};
  assign emit_mid    = (newf_in + FW1'(eff_s)) > WORD_F;
  assign mid_cnt     = 4'(newf_in >> 3);
  assign acc_in      = acc_r | (({ACCW{in_bit}} & ~({ACCW{1'b1}} >> eff_s)) >> fill_r);

  assign newf_rp    = FW1'(fill_r) + FW1'(row_s_r);
  assign full_rp    = newf_rp >= WORD_F;
  assign exact64    = newf_rp == WORD_F;
  assign pk_last    = (pk_col_r + 8'd1) == row_w_r;
  assign final_pass = (rep_r + ONE_S) == row_s_r;
  assign acc_rp     = acc_r | (({ACCW{mem_rd_bit}} & ~({ACCW{1'b1}} >> row_s_r)) >> fill_r);

  assign slot_ok   = !out_valid_r || out_ready;
  assign can_issue = iss_r < row_w_r;
  assign need_out  = full_rp || pk_last;
  assign pk_go     = pk_v_r && (!need_out || slot_ok);
  assign advance   = !pk_v_r || pk_go;
  assign rd_en     = (state_r == ST_RPL) && advance && can_issue;

  // an input that makes no word never waits on the output side
  assign in_ready = (state_r == ST_IN) && (!(row_last_in || emit_mid) || slot_ok);
  assign in_acc   = in_valid && in_ready;

  assign mem_wr_en   = in_acc;
  assign mem_wr_addr = col_r[AW_A-1:0];
  assign mem_wr_bit  = in_bit;
  assign mem_rd_en   = rd_en;
  assign mem_rd_addr = iss_r[AW_A-1:0];

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    row_w_nxt   = row_w_r;
    row_s_nxt   = row_s_r;
    acc_nxt     = acc_r;
    fill_nxt    = fill_r;
    iss_nxt     = iss_r;
    pk_col_nxt  = pk_col_r;
    pk_v_nxt    = pk_v_r;
    rep_nxt     = rep_r;
    sym_row_nxt = sym_row_r;
    em_v        = 1'b0;
    em_beat     = '0;
    pass_done   = 1'b0;
    case (state_r)
      ST_IN: begin
        if (in_acc) begin
          row_w_nxt = eff_w;
          row_s_nxt = eff_s;
          if (!row_last_in) begin
            col_nxt = col_r + 8'd1;
            if (emit_mid) begin
              em_v                = 1'b1;
              em_beat.packed_word = acc_in[ACCW-1 -: WORD_BITS];
              em_beat.byte_count  = mid_cnt;
              em_beat.run_last    = 1'b1;
              acc_nxt  = acc_in << {mid_cnt, 3'b000};
              fill_nxt = FW'(newf_in - FW1'({mid_cnt, 3'b000}));
            end else begin
              acc_nxt  = acc_in;
              fill_nxt = FW'(newf_in);
            end
          end else begin
            em_v                = 1'b1;
            em_beat.packed_word = acc_in[ACCW-1 -: WORD_BITS];
            em_beat.byte_count  = 4'((newf_in + SEVEN) >> 3);
            em_beat.row_end     = 1'b1;
            em_beat.symbol_end  = last_row_in && (eff_s == ONE_S);
            em_beat.run_last    = eff_s == ONE_S;
            acc_nxt     = '0;
            fill_nxt    = '0;
            col_nxt     = 8'd0;
            row_nxt     = last_row_in ? 8'd0 : row_r + 8'd1;
            sym_row_nxt = last_row_in;
            if (eff_s != ONE_S) begin
              state_nxt  = ST_RPL;
              rep_nxt    = ONE_S;
              iss_nxt    = 8'd0;
              pk_col_nxt = 8'd0;
              pk_v_nxt   = 1'b0;
            end
          end
        end
      end
      ST_RPL: begin
        if (rd_en) begin
          iss_nxt = iss_r + 8'd1;
        end
        if (advance) begin
          pk_v_nxt = rd_en;
        end
        if (pk_go) begin
          pk_col_nxt = pk_col_r + 8'd1;
          if (full_rp) begin
            em_v                = 1'b1;
            em_beat.packed_word = acc_rp[ACCW-1 -: WORD_BITS];
            em_beat.byte_count  = 4'd8;
            em_beat.row_end     = pk_last && exact64;
            em_beat.symbol_end  = pk_last && exact64 && sym_row_r && final_pass;
            em_beat.run_last    = pk_last && exact64 && final_pass;
            acc_nxt  = acc_rp << WORD_BITS;
            fill_nxt = FW'(newf_rp - WORD_F);
            if (pk_last) begin
              if (exact64) begin
                pass_done = 1'b1;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
          end else if (pk_last) begin
            em_v                = 1'b1;
            em_beat.packed_word = acc_rp[ACCW-1 -: WORD_BITS];
            em_beat.byte_count  = 4'((newf_rp + SEVEN) >> 3);
            em_beat.row_end     = 1'b1;
            em_beat.symbol_end  = sym_row_r && final_pass;
            em_beat.run_last    = final_pass;
            acc_nxt   = '0;
            fill_nxt  = '0;
            pass_done = 1'b1;
          end else begin
            acc_nxt  = acc_rp;
            fill_nxt = FW'(newf_rp);
          end
        end
      end
      ST_FLUSH: begin
        // remainder of a pass whose last module spilled over a full word
        if (slot_ok) begin
          em_v                = 1'b1;
          em_beat.packed_word = acc_r[ACCW-1 -: WORD_BITS];
          em_beat.byte_count  = 4'((FW1'(fill_r) + SEVEN) >> 3);
          em_beat.row_end     = 1'b1;
          em_beat.symbol_end  = sym_row_r && final_pass;
          em_beat.run_last    = final_pass;
          acc_nxt   = '0;
          fill_nxt  = '0;
          pass_done = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase
    if (pass_done) begin
      pk_col_nxt = 8'd0;
      iss_nxt    = 8'd0;
      if (final_pass) begin
        state_nxt = ST_IN;
      end else begin
        rep_nxt   = rep_r + ONE_S;
        state_nxt = ST_RPL;
      end
    end
  end

  // bytes past the count are zeroed
  assign em_mask = ~({WORD_BITS{1'b1}} >> {em_beat.byte_count, 3'b000});

  always_comb begin
    em_out             = em_beat;
    em_out.packed_word = em_beat.packed_word & em_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      row_w_r     <= MINW8;
      row_s_r     <= ONE_S;
      acc_r       <= '0;
      fill_r      <= '0;
      iss_r       <= 8'd0;
      pk_col_r    <= 8'd0;
      pk_v_r      <= 1'b0;
      rep_r       <= ONE_S;
      sym_row_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      row_w_r   <= row_w_nxt;
      row_s_r   <= row_s_nxt;
      acc_r     <= acc_nxt;
      fill_r    <= fill_nxt;
      iss_r     <= iss_nxt;
      pk_col_r  <= pk_col_nxt;
      pk_v_r    <= pk_v_nxt;
      rep_r     <= rep_nxt;
      sym_row_r <= sym_row_nxt;
      if (em_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_v) begin
      out_beat_r <= em_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  assign chk_fill = FW1'(fill_r) + FW1'(row_s_r);

`include "qr_module_scale_and_pack_core_macros.svh"

  `QRSP_IMPLIES(a_pack_only_in_replay, pk_v_r, state_r == ST_RPL, "pack stage busy outside replay")
  `QRSP_NEXT(a_row_end_starts_replay, in_acc && row_last_in && (eff_s != ONE_S), state_r == ST_RPL, "row end did not start replay")
  `QRSP_IMPLIES(a_count_range, out_valid_r, (out_beat_r.byte_count != 4'd0) && (out_beat_r.byte_count <= 4'd8), "byte count out of range")
  `QRSP_ALWAYS(a_issue_bound, iss_r <= row_w_r, "line store read past row width")
  `QRSP_IMPLIES(a_fill_room, (state_r == ST_IN) && (col_r != 8'd0), chk_fill <= WORD_F, "accumulator has no room for next module")

endmodule

// File: hw/rtl/qr_module_scale_and_pack_core.sv
`timescale 1ns / 1ps

// Scales a square module bitmap and packs it MSB-first into 64-bit words. Module bits enter
// one per beat in row-major order (1 is dark); each is repeated scale times across, and every
// scaled row is zero padded to a byte boundary. The first copy of a row streams out as the
// modules arrive, one module per cycle while the output has room, with a word leaving when the
// next module would no longer fit. The row is also written to a single-port-read line store,
// and after its last module the block replays it scale-1 more times from that store in 8-byte
// words, the last word of each row holding only the bytes it needs and marked in tuser. During
// the replays no input is taken. The store delivers one module per cycle while the output
// takes the words, and a pass whose final module spills across a word boundary ends with a
// flush of the remainder. Inputs that produce no word are taken even while a result beat
// waits. Width and scale are sampled at the first module of each row and saturated to
// 21..MAX_WIDTH and 1..MAX_SCALE. The line store needs no clearing after reset.
module qr_module_scale_and_pack_core #(
  parameter int MAX_WIDTH = qrsp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE = qrsp_pkg::DEF_MAX_SCALE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream, one module per beat
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [qrsp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] module_dark, [7:1] zero
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qrsp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [63:0] packed_word,
                                                         // [67:64] byte_count, [71:68] zero
  output logic [qrsp_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [0] row_end, [1] symbol_end
  output logic                               out_tlast,  // run_last
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qrsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qrsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import qrsp_pkg::*;

  localparam int AW_A = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [7:0] sym_w_r;
  logic [2:0] scale_r;
  cfg_t       cfg;
  beat_t      beat;

  logic            wr_en;
  logic [AW_A-1:0] wr_addr;
  logic            wr_bit;
  logic            rd_en;
  logic [AW_A-1:0] rd_addr;
  logic            rd_bit;

  // register file, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_w_r <= RST_SYMBOL_WIDTH;
      scale_r <= RST_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYMBOL_WIDTH: begin
          sym_w_r <= cfg_data;
        end
        REG_SCALE: begin
          scale_r <= cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.symbol_width = sym_w_r;
  assign cfg.scale        = scale_r;

  // packer: first copy, replay sequencing and the output register
  qrsp_engine #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .AW_A      (AW_A)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_bit      (in_tdata[0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_beat    (beat),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_bit  (wr_bit),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_bit  (rd_bit)
  );

  // one row of modules, replayed for the vertical copies
  qrsp_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW_A)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_bit  (wr_bit),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_bit  (rd_bit)
  );

  // beat packing on the result side
  assign out_tdata = {4'b0000, beat.byte_count, beat.packed_word};
  assign out_tuser = {beat.symbol_end, beat.row_end};
  assign out_tlast = beat.run_last;

endmodule
